@@ sv/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared constants and helper functions for the Gregorian date add-days unit:
// calendar cycle lengths, reciprocal multipliers and month-start offsets.
// ----------------------------------------------------------------------------
package gdad_pkg;

  // default parameter values
  localparam int unsigned YEAR_MAX_DEF    = 9999;
  localparam int unsigned OFFSET_BITS_DEF = 20;

  // field widths
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DOY_W   = 9;

  // zero-based serial day fits here for any supported year limit
  localparam int unsigned N_W     = 25;
  localparam int unsigned Q400_W  = 8;

  // number of register stages from input to result
  localparam int unsigned NSTG    = 8;

  // calendar cycle lengths in days
  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;

  // divide by 100 for values below 2^14: (x * DIV100_MUL) >> DIV100_SH
  localparam int unsigned DIV100_SH  = 19;
  localparam int unsigned DIV100_MUL = ((1 << DIV100_SH) + 99) / 100;
  localparam int unsigned DIV100_MW  = 13;

  // divide by the 400-year cycle for values below 2^25
  localparam int unsigned       DIV400Y_SH  = 43;
  localparam longint unsigned   DIV400Y_MUL =
    ((64'd1 << DIV400Y_SH) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y);
  localparam int unsigned       DIV400Y_MW  = 26;

  // divide by the 4-year cycle for values up to one century
  localparam int unsigned DIV4Y_SH  = 26;
  localparam int unsigned DIV4Y_MUL = ((1 << DIV4Y_SH) + DAYS_4Y - 1) / DAYS_4Y;

  // days in all full years before year y (y >= 1), elaboration use only
  function automatic int unsigned days_before_year(input int unsigned y);
    int unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  // days of the year that lie before the first of month mon
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mon,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    case (mon)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

@@ sv/gregorian_date_add_days_unit.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// Adds a day offset to a Gregorian date through a serial day count and
// converts back, saturating at 31 December of YEAR_MAX.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: start day, month, year and a day offset on in_valid/in_stall.
//   Result beat: day, month, year and an overflow flag on out_valid/out_stall.
//   A beat moves at a clock edge where valid is high and stall is low.
//   One beat is taken every cycle unless the receiver stalls the pipeline.
//   The eight stages are one in-order pipeline: input register,
//   leap/century terms, serial count and limit check, 400-year quotient,
//   century split, 4-year quotient, year and day of year, month lookup.
//   When the receiver stalls, the whole pipeline holds and in_stall follows,
//   so the waiting result stays put and nothing is dropped.
//   Synchronous active-low reset clears all stage valid bits; the first beat
//   is accepted on the cycle after reset is released.
//   Out-of-range months clamp to January/December, year 0 is taken as year 1,
//   and a result past the last supported day reports 31 December of YEAR_MAX
//   with out_overflow set.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_unit #(
  parameter int unsigned YEAR_MAX    = gdad_pkg::YEAR_MAX_DEF,
  parameter int unsigned OFFSET_BITS = gdad_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gdad_pkg::DAY_W-1:0]      in_start_day,
  input  logic [gdad_pkg::MONTH_W-1:0]    in_start_month,
  input  logic [gdad_pkg::YEAR_W-1:0]     in_start_year,
  input  logic [OFFSET_BITS-1:0]          in_offset_days,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gdad_pkg::DAY_W-1:0]      out_result_day,
  output logic [gdad_pkg::MONTH_W-1:0]    out_result_month,
  output logic [gdad_pkg::YEAR_W-1:0]     out_result_year,
  output logic                            out_overflow
);

  import gdad_pkg::*;

  // serial count width and the last supported serial day
  localparam int unsigned SER_W = ((OFFSET_BITS > 23) ? OFFSET_BITS : 23) + 2;
  localparam int unsigned LIMIT = days_before_year(YEAR_MAX + 1);
  localparam int unsigned PM_W  = YEAR_W + DIV100_MW;
  localparam int unsigned P4_W  = N_W + DIV400Y_MW;

  // pipeline advance, shared by every stage
  logic            adv;
  logic [NSTG-1:0] vld_r, vld_nxt;

  assign adv      = !vld_r[NSTG-1] || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld_r[NSTG-1];

  // stage valid shift
  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: input register with month and year clamped
  logic [DAY_W-1:0]       s1_day_r;
  logic [MONTH_W-1:0]     s1_mon_r, s1_mon_nxt;
  logic [YEAR_W-1:0]      s1_year_r, s1_year_nxt;
  logic [OFFSET_BITS-1:0] s1_off_r;

  always_comb begin
    s1_mon_nxt = in_start_month;
    if (in_start_month < 4'd1) begin
      s1_mon_nxt = 4'd1;
    end else if (in_start_month > 4'd12) begin
      s1_mon_nxt = 4'd12;
    end
    s1_year_nxt = (in_start_year == '0) ? YEAR_W'(1) : in_start_year;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_day_r  <= in_start_day;
      s1_mon_r  <= s1_mon_nxt;
      s1_year_r <= s1_year_nxt;
      s1_off_r  <= in_offset_days;
    end
  end

  // stage 2: leap flag, century terms of the full years and month start
  logic [YEAR_W-1:0]      s2_p;
  logic [PM_W-1:0]        s2_pm100, s2_pm400, s2_ym100;
  logic [7:0]             s2_yd100;
  logic [YEAR_W:0]        s2_y100;
  logic                   s2_cent, s2_leap;
  logic [YEAR_W-1:0]      s2_p_r;
  logic [7:0]             s2_pd100_r;
  logic [5:0]             s2_pd400_r;
  logic [DOY_W-1:0]       s2_cum_r;
  logic [DAY_W-1:0]       s2_day_r;
  logic [OFFSET_BITS-1:0] s2_off_r;

  always_comb begin
    s2_p     = s1_year_r - YEAR_W'(1);
    s2_pm100 = PM_W'(s2_p) * PM_W'(DIV100_MUL);
    s2_pm400 = PM_W'(s2_p[YEAR_W-1:2]) * PM_W'(DIV100_MUL);
    s2_ym100 = PM_W'(s1_year_r) * PM_W'(DIV100_MUL);
    s2_yd100 = s2_ym100[DIV100_SH +: 8];
    s2_y100  = (YEAR_W+1)'(s2_yd100) * (YEAR_W+1)'(100);
    s2_cent  = ((YEAR_W+1)'(s1_year_r) == s2_y100);
    s2_leap  = ((s1_year_r[1:0] == 2'b00) && !s2_cent) ||
               (s2_cent && (s2_yd100[1:0] == 2'b00));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p_r     <= s2_p;
      s2_pd100_r <= s2_pm100[DIV100_SH +: 8];
      s2_pd400_r <= s2_pm400[DIV100_SH +: 6];
      s2_cum_r   <= month_start(s1_mon_r, s2_leap);
      s2_day_r   <= s1_day_r;
      s2_off_r   <= s1_off_r;
    end
  end

  // stage 3: serial day count, limit check, zero-based count
  logic [SER_W-1:0] s3_s, s3_sc, s3_n;
  logic [N_W-1:0]   s3_n_r;
  logic             s3_ovf_r;

  always_comb begin
    s3_s = SER_W'(s2_p_r) * SER_W'(DAYS_1Y)
         + SER_W'(s2_p_r[YEAR_W-1:2])
         - SER_W'(s2_pd100_r)
         + SER_W'(s2_pd400_r)
         + SER_W'(s2_cum_r)
         + SER_W'(s2_day_r)
         + SER_W'(s2_off_r);
    s3_sc = (s3_s == '0) ? SER_W'(1) : s3_s;
    s3_n  = s3_sc - SER_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_n_r   <= s3_n[N_W-1:0];
      s3_ovf_r <= (s3_sc > SER_W'(LIMIT));
    end
  end

  // stage 4: number of whole 400-year cycles
  logic [P4_W-1:0]   s4_prod;
  logic [N_W-1:0]    s4_n_r;
  logic [Q400_W-1:0] s4_q400_r;
  logic              s4_ovf_r;

  assign s4_prod = P4_W'(s3_n_r) * P4_W'(DIV400Y_MUL);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_n_r    <= s3_n_r;
      s4_q400_r <= s4_prod[DIV400Y_SH +: Q400_W];
      s4_ovf_r  <= s3_ovf_r;
    end
  end

  // stage 5: split the cycle remainder into centuries, last one may be long
  logic [N_W-1:0]    s5_r;
  logic [17:0]       s5_r18;
  logic [1:0]        s5_q100;
  logic [17:0]       s5_sub;
  logic [17:0]       s5_r2;
  logic [Q400_W-1:0] s5_q400_r;
  logic [1:0]        s5_q100_r;
  logic [15:0]       s5_r2_r;
  logic              s5_ovf_r;

  always_comb begin
    s5_r   = s4_n_r - N_W'(s4_q400_r) * N_W'(DAYS_400Y);
    s5_r18 = s5_r[17:0];
    if (s5_r18 >= 18'(3 * DAYS_100Y)) begin
      s5_q100 = 2'd3;
    end else if (s5_r18 >= 18'(2 * DAYS_100Y)) begin
      s5_q100 = 2'd2;
    end else if (s5_r18 >= 18'(DAYS_100Y)) begin
      s5_q100 = 2'd1;
    end else begin
      s5_q100 = 2'd0;
    end
    s5_sub = 18'(s5_q100) * 18'(DAYS_100Y);
    s5_r2  = s5_r18 - s5_sub;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_q400_r <= s4_q400_r;
      s5_q100_r <= s5_q100;
      s5_r2_r   <= s5_r2[15:0];
      s5_ovf_r  <= s4_ovf_r;
    end
  end

  // stage 6: number of whole 4-year cycles in the century
  logic [31:0]       s6_prod;
  logic [Q400_W-1:0] s6_q400_r;
  logic [1:0]        s6_q100_r;
  logic [4:0]        s6_q4_r;
  logic [15:0]       s6_r2_r;
  logic              s6_ovf_r;

  assign s6_prod = 32'(s5_r2_r) * 32'(DIV4Y_MUL);

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_q400_r <= s5_q400_r;
      s6_q100_r <= s5_q100_r;
      s6_q4_r   <= s6_prod[DIV4Y_SH +: 5];
      s6_r2_r   <= s5_r2_r;
      s6_ovf_r  <= s5_ovf_r;
    end
  end

  // stage 7: year within the 4-year cycle, year number, day of year
  logic [15:0]        s7_r3w;
  logic [10:0]        s7_r3;
  logic [1:0]         s7_q1;
  logic [10:0]        s7_r4;
  logic [16:0]        s7_year;
  logic               s7_leap;
  logic [DOY_W-1:0]   s7_doy_r;
  logic               s7_leap_r;
  logic [YEAR_W-1:0]  s7_year_r;
  logic               s7_ovf_r;

  always_comb begin
    s7_r3w = s6_r2_r - 16'(s6_q4_r) * 16'(DAYS_4Y);
    s7_r3  = s7_r3w[10:0];
    if (s7_r3 >= 11'(3 * DAYS_1Y)) begin
      s7_q1 = 2'd3;
    end else if (s7_r3 >= 11'(2 * DAYS_1Y)) begin
      s7_q1 = 2'd2;
    end else if (s7_r3 >= 11'(DAYS_1Y)) begin
      s7_q1 = 2'd1;
    end else begin
      s7_q1 = 2'd0;
    end
    s7_r4   = s7_r3 - 11'(s7_q1) * 11'(DAYS_1Y);
    s7_year = 17'(s6_q400_r) * 17'd400 + 17'(s6_q100_r) * 17'd100
            + 17'(s6_q4_r) * 17'd4 + 17'(s7_q1) + 17'd1;
    // fourth year of a 4-year cycle leaps, unless it closes a plain century
    s7_leap = (s7_q1 == 2'd3) && ((s6_q4_r != 5'd24) || (s6_q100_r == 2'd3));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_doy_r  <= s7_r4[DOY_W-1:0] + DOY_W'(1);
      s7_leap_r <= s7_leap;
      s7_year_r <= s7_year[YEAR_W-1:0];
      s7_ovf_r  <= s6_ovf_r;
    end
  end

  // stage 8: month from day of year, saturation, result register
  logic [MONTH_W-1:0] s8_mon;
  logic [DOY_W-1:0]   s8_dom;
  logic [DAY_W-1:0]   res_day_r;
  logic [MONTH_W-1:0] res_mon_r;
  logic [YEAR_W-1:0]  res_year_r;
  logic               res_ovf_r;

  always_comb begin
    s8_mon = MONTH_W'(1);
    for (int m = 2; m <= 12; m++) begin
      if (s7_doy_r > month_start(MONTH_W'(m), s7_leap_r)) begin
        s8_mon = MONTH_W'(m);
      end
    end
    s8_dom = s7_doy_r - month_start(s8_mon, s7_leap_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_ovf_r <= s7_ovf_r;
      if (s7_ovf_r) begin
        res_day_r  <= DAY_W'(31);
        res_mon_r  <= MONTH_W'(12);
        res_year_r <= YEAR_W'(YEAR_MAX);
      end else begin
        res_day_r  <= s8_dom[DAY_W-1:0];
        res_mon_r  <= s8_mon;
        res_year_r <= s7_year_r;
      end
    end
  end

  assign out_result_day   = res_day_r;
  assign out_result_month = res_mon_r;
  assign out_result_year  = res_year_r;
  assign out_overflow     = res_ovf_r;

`ifndef SYNTHESIS
  // saturated results always carry the last day of the year
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> (out_result_day == DAY_W'(31)) &&
                                  (out_result_month == MONTH_W'(12)))
    else $error("overflow result not saturated");

  // month in range and day inside a month
  a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_month >= MONTH_W'(1)) &&
                  (out_result_month <= MONTH_W'(12)) &&
                  (out_result_day >= DAY_W'(1)) && (out_result_day <= DAY_W'(31)))
    else $error("result date out of range");

  // february never passes its leap-day
  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_month == MONTH_W'(2)) |-> (out_result_day <= DAY_W'(29)))
    else $error("february day beyond 29");

  // a held result keeps the whole pipeline frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while result stalled");
`endif

endmodule

@@ bench/tb_gregorian_date_add_days_unit.sv @@
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days_unit
// Self-checking bench for the date add-days unit. Each input beat goes
// through a calendar predictor built on a serial day count, and the expected
// date is queued. Every result beat is compared field by field with the
// oldest queued date. Stimulus covers calendar corners, out-of-range fields,
// random calendar dates with offsets of many sizes, raw random fields, and a
// closing back-to-back stretch. Both sides stall in random bursts until then.
// ----------------------------------------------------------------------------
module tb_gregorian_date_add_days_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import gdad_pkg::*;

  localparam int unsigned YEAR_LIMIT  = YEAR_MAX_DEF;
  localparam int unsigned OFF_W       = OFFSET_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [OFF_W-1:0]   offset;
  } date_req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               overflow;
  } date_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DAY_W-1:0]   in_start_day = '0;
  logic [MONTH_W-1:0] in_start_month = '0;
  logic [YEAR_W-1:0]  in_start_year = '0;
  logic [OFF_W-1:0]   in_offset_days = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DAY_W-1:0]   out_result_day;
  logic [MONTH_W-1:0] out_result_month;
  logic [YEAR_W-1:0]  out_result_year;
  logic               out_overflow;

  date_res_t   pending_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          idle_en = 1'b0;

  gregorian_date_add_days_unit #(
    .YEAR_MAX    (YEAR_LIMIT),
    .OFFSET_BITS (OFF_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_day     (in_start_day),
    .in_start_month   (in_start_month),
    .in_start_year    (in_start_year),
    .in_offset_days   (in_offset_days),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year),
    .out_overflow     (out_overflow)
  );

  // clock
  always #5 clk = ~clk;

  // calendar helpers
  function automatic bit leap_year(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, bit leap);
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic longint unsigned days_ahead_of_year(longint unsigned y);
    longint unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  // expected date for one input beat
  function automatic date_res_t predict_later_date(date_req_t req);
    longint unsigned mon, yr, serial, limit, n, q400, r, q100, q4, q1;
    int unsigned     m;
    bit              leap;
    date_res_t       res;
    mon = req.month;
    yr  = req.year;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    if (yr < 1) yr = 1;
    leap   = leap_year(yr);
    serial = days_ahead_of_year(yr);
    for (m = 1; m < mon; m++) serial += days_in_month(m, leap);
    serial += longint'(req.day) + longint'(req.offset);
    if (serial < 1) serial = 1;
    limit = days_ahead_of_year(longint'(YEAR_LIMIT) + 1);
    if (serial > limit) begin
      res.day      = DAY_W'(31);
      res.month    = MONTH_W'(12);
      res.year     = YEAR_W'(YEAR_LIMIT);
      res.overflow = 1'b1;
      return res;
    end
    // split the serial count into 400/100/4/1 year cycles
    n    = serial - 1;
    q400 = n / DAYS_400Y;
    r    = n % DAYS_400Y;
    q100 = r / DAYS_100Y;
    if (q100 > 3) q100 = 3;
    r  = r - q100 * DAYS_100Y;
    q4 = r / DAYS_4Y;
    r  = r % DAYS_4Y;
    q1 = r / 365;
    if (q1 > 3) q1 = 3;
    r    = r - q1 * 365 + 1;
    yr   = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
    leap = leap_year(yr);
    m    = 1;
    while (m < 12 && r > days_in_month(m, leap)) begin
      r = r - days_in_month(m, leap);
      m++;
    end
    res.day      = DAY_W'(r);
    res.month    = MONTH_W'(m);
    res.year     = YEAR_W'(yr);
    res.overflow = 1'b0;
    return res;
  endfunction

  // random valid calendar date with an offset of varied size
  function automatic date_req_t random_calendar_date();
    date_req_t   req;
    int unsigned y, mo, len;
    case ($urandom_range(0, 3))
      0:       y = $urandom_range(1, YEAR_LIMIT);
      1:       y = $urandom_range(0, 99) * 100 + $urandom_range(0, 4);
      2:       y = $urandom_range(YEAR_LIMIT - 9, YEAR_LIMIT);
      default: y = $urandom_range(1, 50);
    endcase
    if (y < 1) y = 1;
    mo  = $urandom_range(1, 12);
    len = days_in_month(mo, leap_year(y));
    req.year  = YEAR_W'(y);
    req.month = MONTH_W'(mo);
    case ($urandom_range(0, 3))
      0:       req.day = DAY_W'(1);
      1:       req.day = DAY_W'(len);
      2:       req.day = DAY_W'(len - 1);
      default: req.day = DAY_W'($urandom_range(1, len));
    endcase
    case ($urandom_range(0, 4))
      0:       req.offset = OFF_W'($urandom_range(0, 31));
      1:       req.offset = OFF_W'($urandom_range(0, 400));
      2:       req.offset = OFF_W'($urandom_range(0, 40000));
      3:       req.offset = OFF_W'($urandom);
      default: req.offset = '1;
    endcase
    return req;
  endfunction

  // mismatch report, one line each
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // send one beat, with an optional random gap ahead of it
  task automatic send_date(date_req_t req);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_start_day   <= req.day;
    in_start_month <= req.month;
    in_start_year  <= req.year;
    in_offset_days <= req.offset;
    in_valid       <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_dates.push_back(predict_later_date(req));
  endtask

  task automatic send_fields(int unsigned d, int unsigned mo, int unsigned y,
                             int unsigned off);
    date_req_t req;
    req.day    = DAY_W'(d);
    req.month  = MONTH_W'(mo);
    req.year   = YEAR_W'(y);
    req.offset = OFF_W'(off);
    send_date(req);
  endtask

  // calendar corners: year 1, leap rules, month ends, saturation boundary
  task automatic test_calendar_corners();
    send_fields(1, 1, 1, 0);
    send_fields(28, 2, 1900, 1);
    send_fields(28, 2, 2000, 1);
    send_fields(29, 2, 2004, 365);
    send_fields(31, 12, 1999, 1);
    send_fields(31, 12, 2399, 366);
    send_fields(1, 1, 2000, DAYS_400Y);
    send_fields(31, 12, YEAR_LIMIT, 0);
    send_fields(31, 12, YEAR_LIMIT, 1);
    send_fields(1, 1, 1, (1 << OFF_W) - 1);
    send_fields(31, 12, YEAR_LIMIT, (1 << OFF_W) - 1);
    send_fields(30, 12, YEAR_LIMIT - 1, 366);
  endtask

  // fields outside the calendar: month and year clamps, day zero, day carry
  task automatic test_field_clamps();
    send_fields(0, 1, 1, 0);
    send_fields(0, 3, 2000, 0);
    send_fields(0, 1, 2001, 0);
    send_fields(31, 2, 2001, 0);
    send_fields(31, 2, 2004, 0);
    send_fields(15, 0, 2023, 10);
    send_fields(15, 13, 2023, 10);
    send_fields(1, 14, 1, 0);
    send_fields(31, 15, 2020, 5);
    send_fields(1, 1, 0, 0);
    send_fields(1, 1, YEAR_LIMIT + 1, 0);
    send_fields(31, 15, (1 << YEAR_W) - 1, (1 << OFF_W) - 1);
  endtask

  task automatic test_random_dates(int unsigned count);
    repeat (count) send_date(random_calendar_date());
  endtask

  // every field fully random
  task automatic test_raw_fields(int unsigned count);
    date_req_t req;
    repeat (count) begin
      req.day    = DAY_W'($urandom);
      req.month  = MONTH_W'($urandom);
      req.year   = YEAR_W'($urandom);
      req.offset = OFF_W'($urandom);
      send_date(req);
    end
  endtask

  // result side: burst stalls
  always @(posedge clk) begin
    if (!idle_en) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 14);
    end
  end

  // result check against the oldest pending date
  always @(posedge clk) begin
    date_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_result_day !== want.day)
          report_mismatch("day", out_result_day, want.day);
        if (out_result_month !== want.month)
          report_mismatch("month", out_result_month, want.month);
        if (out_result_year !== want.year)
          report_mismatch("year", out_result_year, want.year);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_gregorian_date_add_days_unit failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n   <= 1'b1;
    idle_en = 1'b1;
    @(posedge clk);
    test_calendar_corners();
    test_field_clamps();
    test_random_dates(450);
    test_raw_fields(150);
    // idling off right away so the closing stretch runs back to back
    idle_en = 1'b0;
    test_random_dates(100);
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (NSTG + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_gregorian_date_add_days_unit passed");
    end else begin
      $display("tb_gregorian_date_add_days_unit failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/gdad_pkg.sv
sv/gregorian_date_add_days_unit.sv
bench/tb_gregorian_date_add_days_unit.sv
